>>> design/kmds_pkg.sv
// Package for the keypad matrix scanner: field widths, codes and shared types.
package kmds_pkg;

    // Fixed field widths
    localparam int LEVEL_W = 5;
    localparam int HELD_W  = 25;
    localparam int CNT_W   = 16;
    localparam int LKEY_W  = 5;
    localparam int DRIVE_W = 5;
    localparam int KIND_W  = 2;
    localparam int KIDX_W  = 5;
    // Key number inside the block; covers up to 8 x 8 keys
    localparam int KEY_W   = 6;

    // Event kinds
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REL    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LONG_A = 2'd2;
    localparam logic [KIND_W-1:0] KIND_LONG_B = 2'd3;

    // Register indexes on the APB port
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_PRESS_THR = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COUNT_CAP = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_REL_LIMIT = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LONG_KEYA = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LONG_CNTA = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LONG_KEYB = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_LONG_CNTB = 3'd6;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Register reset values
    localparam logic [CNT_W-1:0]  RST_PRESS_THR = 16'd1500;
    localparam logic [CNT_W-1:0]  RST_COUNT_CAP = 16'd60000;
    localparam logic [CNT_W-1:0]  RST_REL_LIMIT = 16'd50000;
    localparam logic [LKEY_W-1:0] RST_LONG_KEYA = 5'd21;
    localparam logic [CNT_W-1:0]  RST_LONG_CNTA = 16'd50000;
    localparam logic [LKEY_W-1:0] RST_LONG_KEYB = 5'd16;
    localparam logic [CNT_W-1:0]  RST_LONG_CNTB = 16'd5000;

    // Configuration seen by every lane
    typedef struct packed {
        logic [CNT_W-1:0]  press_thr;
        logic [CNT_W-1:0]  count_cap;
        logic [CNT_W-1:0]  rel_limit;
        logic [LKEY_W-1:0] long_key_a;
        logic [CNT_W-1:0]  long_cnt_a;
        logic [LKEY_W-1:0] long_key_b;
        logic [CNT_W-1:0]  long_cnt_b;
    } t_cfg;

    // What one column lane found for the current row
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              set_held;
        logic [KEY_W-1:0]  key;
    } t_lane_res;

    // Merged outcome of the row
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key;
    } t_merge_res;

endpackage

>>> design/kmds_if.sv
// Handshake channels of the keypad matrix scanner: sample input and result output.
interface kmds_in_if;
    logic                        valid;
    logic                        ready;
    logic [kmds_pkg::LEVEL_W-1:0] column_levels;
    logic [kmds_pkg::HELD_W-1:0]  flag_clear_mask;

    modport source (output valid, output column_levels, output flag_clear_mask, input ready);
    modport sink   (input valid, input column_levels, input flag_clear_mask, output ready);
endinterface

interface kmds_out_if;
    logic                        valid;
    logic                        ready;
    logic [kmds_pkg::DRIVE_W-1:0] row_drive;
    logic [kmds_pkg::KIND_W-1:0]  event_kind;
    logic [kmds_pkg::KIDX_W-1:0]  key_index;
    logic [kmds_pkg::HELD_W-1:0]  held_flags;

    modport source (output valid, output row_drive, output event_kind, output key_index,
                    output held_flags, input ready);
    modport sink   (input valid, input row_drive, input event_kind, input key_index,
                    input held_flags, output ready);
endinterface

>>> design/keypad_matrix_debounce_scanner.sv
// Top level of the keypad matrix scanner: config registers, lanes, row pointer, output register.
//
// Usage: each item on i_in carries the column levels sampled for the row that the
// previous result's row_drive selected, plus a mask of held flags to clear. Each item
// yields exactly one result on o_out: the one-hot drive for the next row, an event
// (release, long press a, long press b, or none) with its key index, and the held flags.
// The result of an item is valid in the cycle after acceptance.
// Throughput is one item per cycle while the receiver takes the results; the hold counters
// of a row are updated by one lane per column, and the next item depends on that update
// and on the row pointer, both of which settle at the same edge.
// i_in.ready is high whenever the output register is empty or being taken, so a stalled
// receiver holds the current result and stops intake after one item.
// Reset (synchronous, active low) clears all counters, held flags and the row pointer
// (scan begins at row 0) and loads the default register values; no clearing pass.
// Registers are written over APB at byte address 4*index; reads return their values.
module keypad_matrix_debounce_scanner #(
    parameter int ROWS = 5,
    parameter int COLS = 5
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [kmds_pkg::PADDR_W-1:0]     paddr,
    input  logic [kmds_pkg::PDATA_W-1:0]     pwdata,
    output logic [kmds_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready,
    kmds_in_if.sink                          i_in,
    kmds_out_if.source                       o_out
);
    import kmds_pkg::*;

    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

    t_cfg              r_cfg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic              cfg_wr;

    logic [RW-1:0]     r_row;
    logic [RW-1:0]     n_row;
    logic [HELD_W-1:0] r_held;
    logic [HELD_W-1:0] n_held;
    logic              acc_in;

    t_lane_res         lane_res [COLS];
    t_merge_res        merge_res;
    logic [COLS-1:0]   commit;

    logic              r_valid;
    logic [DRIVE_W-1:0] r_drive;
    logic [DRIVE_W-1:0] n_drive;
    logic [KIND_W-1:0] r_kind;
    logic [KIDX_W-1:0] r_kidx;
    logic [HELD_W-1:0] r_oheld;

    // Configuration port
    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.press_thr  <= RST_PRESS_THR;
            r_cfg.count_cap  <= RST_COUNT_CAP;
            r_cfg.rel_limit  <= RST_REL_LIMIT;
            r_cfg.long_key_a <= RST_LONG_KEYA;
            r_cfg.long_cnt_a <= RST_LONG_CNTA;
            r_cfg.long_key_b <= RST_LONG_KEYB;
            r_cfg.long_cnt_b <= RST_LONG_CNTB;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_PRESS_THR: r_cfg.press_thr  <= pwdata[CNT_W-1:0];
                REG_COUNT_CAP: r_cfg.count_cap  <= pwdata[CNT_W-1:0];
                REG_REL_LIMIT: r_cfg.rel_limit  <= pwdata[CNT_W-1:0];
                REG_LONG_KEYA: r_cfg.long_key_a <= pwdata[LKEY_W-1:0];
                REG_LONG_CNTA: r_cfg.long_cnt_a <= pwdata[CNT_W-1:0];
                REG_LONG_KEYB: r_cfg.long_key_b <= pwdata[LKEY_W-1:0];
                REG_LONG_CNTB: r_cfg.long_cnt_b <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read mux
    always_comb begin
        case (reg_idx)
            REG_PRESS_THR: prdata = PDATA_W'(r_cfg.press_thr);
            REG_COUNT_CAP: prdata = PDATA_W'(r_cfg.count_cap);
            REG_REL_LIMIT: prdata = PDATA_W'(r_cfg.rel_limit);
            REG_LONG_KEYA: prdata = PDATA_W'(r_cfg.long_key_a);
            REG_LONG_CNTA: prdata = PDATA_W'(r_cfg.long_cnt_a);
            REG_LONG_KEYB: prdata = PDATA_W'(r_cfg.long_key_b);
            REG_LONG_CNTB: prdata = PDATA_W'(r_cfg.long_cnt_b);
            default:       prdata = '0;
        endcase
    end

    // Intake whenever the output register frees up
    assign i_in.ready = !r_valid || o_out.ready;
    assign acc_in     = i_in.valid && i_in.ready;

    // Column lanes
    for (genvar c = 0; c < COLS; c++) begin : g_lane
        logic pressed;
        if (c < LEVEL_W) begin : g_col
            assign pressed = i_in.column_levels[c];
        end else begin : g_nocol
            assign pressed = 1'b0;
        end
        kmds_lane #(
            .ROWS (ROWS),
            .COLS (COLS),
            .COL  (c)
        ) u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cfg     (r_cfg),
            .i_row     (r_row),
            .i_pressed (pressed),
            .i_commit  (acc_in && commit[c]),
            .o_res     (lane_res[c])
        );
    end

    kmds_merge #(
        .COLS (COLS)
    ) u_merge (
        .i_lane   (lane_res),
        .o_res    (merge_res),
        .o_commit (commit)
    );

    // Held flags: clear first, then latch keys reaching the threshold
    always_comb begin
        n_held = r_held & ~i_in.flag_clear_mask;
        for (int c = 0; c < COLS; c++) begin
            if (commit[c] && lane_res[c].set_held && lane_res[c].key < KEY_W'(HELD_W)) begin
                n_held[lane_res[c].key[KIDX_W-1:0]] = 1'b1;
            end
        end
    end

    // Next row: restart on any event, else advance and wrap
    always_comb begin
        if (merge_res.kind != KIND_NONE || int'(r_row) >= ROWS - 1) begin
            n_row = '0;
        end else begin
            n_row = r_row + RW'(1);
        end
        for (int i = 0; i < DRIVE_W; i++) begin
            n_drive[i] = (int'(n_row) == i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_held <= '0;
        end else if (acc_in) begin
            r_row  <= n_row;
            r_held <= n_held;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (acc_in) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_drive <= n_drive;
            r_kind  <= merge_res.kind;
            r_kidx  <= merge_res.key[KIDX_W-1:0];
            r_oheld <= n_held;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.row_drive  = r_drive;
    assign o_out.event_kind = r_kind;
    assign o_out.key_index  = r_kidx;
    assign o_out.held_flags = r_oheld;

`ifndef SYNTHESIS
    // an event always sends the scan back to row 0
    a_event_row0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.event_kind != KIND_NONE) |-> (o_out.row_drive == DRIVE_W'(1)))
        else $error("event result does not restart at row 0");

    // no event means no key index
    a_none_key0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.event_kind == KIND_NONE) |-> (o_out.key_index == '0))
        else $error("key index set without event");

    // row pointer and held flags move only with an accepted item
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !acc_in |=> ($stable(r_row) && $stable(r_held)))
        else $error("scan state changed without an item");

    // row pointer stays inside the matrix
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_row) < ROWS)
        else $error("row pointer out of range");
`endif

endmodule

>>> design/kmds_lane.sv
// One column lane: hold counters of its column and the per-key debounce decision.
module kmds_lane #(
    parameter int ROWS = 5,
    parameter int COLS = 5,
    parameter int COL  = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  kmds_pkg::t_cfg        i_cfg,
    input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] i_row,
    input  logic                  i_pressed,
    input  logic                  i_commit,
    output kmds_pkg::t_lane_res   o_res
);
    import kmds_pkg::*;

    logic [CNT_W-1:0] r_cnt [ROWS];
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] inc;
    logic [CNT_W-1:0] n_cnt;
    logic             wr;
    logic [KEY_W-1:0] key;

    assign cnt = r_cnt[i_row];
    assign inc = cnt + CNT_W'(1);
    assign key = KEY_W'(i_row) * KEY_W'(COLS) + KEY_W'(COL);

    // Count up while pressed, clear on release, flag events
    always_comb begin
        o_res.key      = key;
        o_res.kind     = KIND_NONE;
        o_res.set_held = 1'b0;
        n_cnt          = '0;
        wr             = 1'b0;
        if (i_pressed) begin
            if (cnt < i_cfg.count_cap) begin
                n_cnt          = inc;
                wr             = 1'b1;
                o_res.set_held = (inc == i_cfg.press_thr);
                if (key == KEY_W'(i_cfg.long_key_a) && inc == i_cfg.long_cnt_a) begin
                    o_res.kind = KIND_LONG_A;
                end else if (key == KEY_W'(i_cfg.long_key_b) && inc == i_cfg.long_cnt_b) begin
                    o_res.kind = KIND_LONG_B;
                end
            end
        end else begin
            wr = 1'b1;
            // column 1 keys held very long give no release event
            if (cnt > i_cfg.press_thr && (COL != 1 || cnt < i_cfg.rel_limit)) begin
                o_res.kind = KIND_REL;
            end
        end
    end

    // Counter storage, one entry per row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++) begin
                r_cnt[r] <= '0;
            end
        end else if (i_commit && wr) begin
            r_cnt[i_row] <= n_cnt;
        end
    end

endmodule

>>> design/kmds_merge.sv
// Merge stage: picks the lowest column with an event and gates the later lanes.
module kmds_merge #(
    parameter int COLS = 5
) (
    input  kmds_pkg::t_lane_res  i_lane [COLS],
    output kmds_pkg::t_merge_res o_res,
    output logic [COLS-1:0]      o_commit
);
    import kmds_pkg::*;

    logic found;

    // Column priority: the first event ends the row
    always_comb begin
        found     = 1'b0;
        o_res     = '0;
        o_commit  = '0;
        for (int c = 0; c < COLS; c++) begin
            o_commit[c] = !found;
            if (!found && i_lane[c].kind != KIND_NONE) begin
                o_res.kind = i_lane[c].kind;
                o_res.key  = i_lane[c].key;
                found      = 1'b1;
            end
        end
    end

endmodule
